// ===== design/utf8tok_pkg.sv =====
// Shared types and constants of the UTF-8 folding word tokeniser.
// Used by the front end, the bundle queue, the back end, the top level and the checker.
// No dependencies.
package utf8tok_pkg;

    // Limits of the tokeniser
    localparam int MAX_TOKEN_COUNT   = 64;
    localparam int TOKEN_BUFFER_SIZE = 48;
    localparam int TOKEN_LIMIT       = (MAX_TOKEN_COUNT > 127) ? 127 : MAX_TOKEN_COUNT;
    localparam int LEN_W             = 6;
    localparam int TOTAL_W           = 7;

    // Results one input item may cause
    localparam int MAX_RESULTS = 8;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = RES_IDX_W + 1;

    // Queue depths
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);

    // Result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_TOTAL = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last_in_run;
    } out_item_t;

    // One result inside a bundle; the run mark is added by the back end
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } result_t;

    // All results caused by one input item
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [RES_IDX_W-1:0]      last_idx;
    } bundle_t;

endpackage

// ===== design/utf8_folding_word_tokenizer_core.sv =====
// UTF-8 folding word tokeniser, top level.
// Joins the front end, bundle queue and back end; depends on utf8tok_pkg.
//
// Use: bytes of a text enter on item while full is low and push is high; one
// byte per transfer, end_of_string marks the last byte of the text. Results
// leave as a queue: while empty is low the oldest result is on result, and a
// transfer happens when pop is high. Each byte is held until the next arrives
// as lookahead, so its results appear with the following byte; the final
// byte also flushes the open token and the total.
// Path: the first result caused by a transfer is taken by the bundle queue at
// the transfer edge; the back end then moves it into the output queue, from
// which it is on result.
// Throughput: one byte per cycle into the front end while full is low; the
// back end delivers one result per cycle while the output queue has room,
// and an item with no results never reaches it.
// A two-bundle queue and a four-entry output queue decouple the two sides.
// When the receiver stalls, the output queue fills, the back end holds, the
// bundle queue fills and full rises; nothing is dropped.
// Reset clears the lookahead, the token state and both queues at once.
module utf8_folding_word_tokenizer_core
    import utf8tok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic    accept;
    logic    bundle_push;
    bundle_t bundle_in, bundle_head;
    logic    q_empty, q_pop;

    assign accept = push && !full;

    utf8tok_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .bundle_push (bundle_push),
        .bundle      (bundle_in)
    );

    utf8tok_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bundle_push),
        .wr_data (bundle_in),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (bundle_head),
        .empty   (q_empty)
    );

    utf8tok_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (bundle_head),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== design/utf8tok_front.sv =====
// Front end: holds the lookahead byte and the token state, folds accents and
// turns each accepted byte into a bundle of results.
// Depends on utf8tok_pkg.
module utf8tok_front
    import utf8tok_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output logic     bundle_push,
    output bundle_t  bundle
);

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] LEAD_C3  = 8'hC3;
    localparam logic [7:0] LEAD_C5  = 8'hC5;

    typedef struct packed {
        logic [LEN_W-1:0]          len;
        logic [TOTAL_W-1:0]        total;
        logic                      letter;
        logic                      digit;
        logic                      odd;
        logic                      skip;
        logic                      consumed;
        logic [RES_CNT_W-1:0]      n;
        result_t [MAX_RESULTS-1:0] res;
    } work_t;

    typedef struct packed {
        logic [1:0] n;
        logic [7:0] p0;
        logic [7:0] p1;
    } fold_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_lower(logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_upper(logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic below_limit(logic [TOTAL_W-1:0] total);
        return total < TOTAL_W'(TOKEN_LIMIT);
    endfunction

    function automatic work_t emit(work_t w, logic [1:0] kind, logic [7:0] value);
        work_t r;
        r = w;
        if (r.n < RES_CNT_W'(MAX_RESULTS))
        begin
            r.res[r.n[RES_IDX_W-1:0]] = '{kind: kind, value: value};
            r.n = r.n + RES_CNT_W'(1);
        end
        return r;
    endfunction

    function automatic work_t take_char(work_t w, logic [7:0] c);
        work_t r;
        r = w;
        if (r.len < LEN_W'(TOKEN_BUFFER_SIZE - 1))
        begin
            r.len = r.len + LEN_W'(1);
            if (is_lower(c))
                r.letter = 1'b1;
            if (is_digit(c))
                r.digit = 1'b1;
            else if (c != CH_DOT)
                r.odd = 1'b0;
            if (below_limit(r.total))
                r = emit(r, KIND_CHAR, c);
        end
        return r;
    endfunction

    function automatic work_t close_token(work_t w);
        work_t r;
        r = w;
        if ((r.len != '0) && below_limit(r.total))
        begin
            r = emit(r, KIND_END, 8'h00);
            r.total = r.total + TOTAL_W'(1);
        end
        r.len    = '0;
        r.letter = 1'b0;
        r.digit  = 1'b0;
        r.odd    = 1'b1;
        return r;
    endfunction

    // Fold a two-byte Latin sequence to at most two ASCII letters
    function automatic fold_t fold(logic [7:0] a, logic [7:0] b);
        fold_t      f;
        logic [7:0] l;
        f = '{n: 2'd0, p0: 8'h00, p1: 8'h00};
        l = b & 8'hDF;
        if (a == LEAD_C5)
        begin
            if ((b == 8'h92) || (b == 8'h93))
                f = '{n: 2'd2, p0: "o", p1: "e"};
        end
        else if ((a == LEAD_C3) && (b >= 8'h80) && (b <= 8'hBF))
        begin
            if (b == 8'h9F)
                f = '{n: 2'd2, p0: "s", p1: "s"};
            else if (b == 8'hBF)
                f = '{n: 2'd1, p0: "y", p1: 8'h00};
            else if (l == 8'h84)
                f = '{n: 2'd2, p0: "a", p1: "e"};
            else if (l == 8'h96)
                f = '{n: 2'd2, p0: "o", p1: "e"};
            else if (l == 8'h9C)
                f = '{n: 2'd2, p0: "u", p1: "e"};
            else if (((l >= 8'h80) && (l <= 8'h83)) || (l == 8'h85))
                f = '{n: 2'd1, p0: "a", p1: 8'h00};
            else if (l == 8'h87)
                f = '{n: 2'd1, p0: "c", p1: 8'h00};
            else if ((l >= 8'h88) && (l <= 8'h8B))
                f = '{n: 2'd1, p0: "e", p1: 8'h00};
            else if ((l >= 8'h8C) && (l <= 8'h8F))
                f = '{n: 2'd1, p0: "i", p1: 8'h00};
            else if (l == 8'h91)
                f = '{n: 2'd1, p0: "n", p1: 8'h00};
            else if ((l >= 8'h92) && (l <= 8'h95))
                f = '{n: 2'd1, p0: "o", p1: 8'h00};
            else if ((l >= 8'h99) && (l <= 8'h9B))
                f = '{n: 2'd1, p0: "u", p1: 8'h00};
            else if (l == 8'h9D)
                f = '{n: 2'd1, p0: "y", p1: 8'h00};
        end
        return f;
    endfunction

    // Handle byte a with lookahead la (zero for none)
    function automatic work_t process_byte(work_t w, logic [7:0] a, logic [7:0] la);
        work_t r;
        fold_t f;
        r = w;
        r.consumed = 1'b0;
        f = fold(a, la);
        if (!a[7])
        begin
            if (is_upper(a))
                r = take_char(r, a + 8'd32);
            else if (is_lower(a) || is_digit(a))
                r = take_char(r, a);
            else if ((a == CH_MINUS) && r.letter &&
                     (is_upper(la) || is_lower(la) || la[7]))
                r = close_token(r);
            else if (((a == CH_DOT) || (a == CH_COMMA)) && is_digit(la) &&
                     ((r.len == '0) || (r.odd && r.digit)))
                r = take_char(r, CH_DOT);
            else
            begin
                r = close_token(r);
                if (((a == CH_PLUS) || (a == CH_MINUS) || (a == CH_STAR) ||
                     (a == CH_SLASH) || (a == CH_EQUAL)) && below_limit(r.total))
                begin
                    r = emit(r, KIND_CHAR, a);
                    r = emit(r, KIND_END, 8'h00);
                    r.total = r.total + TOTAL_W'(1);
                end
            end
        end
        else if ((la != 8'h00) && (f.n != 2'd0))
        begin
            r = take_char(r, f.p0);
            if (f.n == 2'd2)
                r = take_char(r, f.p1);
            r.consumed = 1'b1;
        end
        else
        begin
            r = close_token(r);
            r.skip = 1'b1;
        end
        return r;
    endfunction

    logic [7:0]         pending_byte_reg, pending_byte_next;
    logic               pending_valid_reg, pending_valid_next;
    logic               skip_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               letter_reg, digit_reg, odd_reg;
    logic               keep;
    work_t              w;
    logic [RES_CNT_W-1:0] n_minus_one;

    always_comb
    begin
        w          = '0;
        w.len      = len_reg;
        w.total    = total_reg;
        w.letter   = letter_reg;
        w.digit    = digit_reg;
        w.odd      = odd_reg;
        w.skip     = skip_reg;
        keep       = 1'b1;
        pending_byte_next  = pending_byte_reg;
        pending_valid_next = pending_valid_reg;

        if (pending_valid_reg)
        begin
            pending_valid_next = 1'b0;
            w = process_byte(w, pending_byte_reg, item.in_byte);
        end

        // A folded pair swallows the lookahead; skip continuation bytes of a split sequence
        if (w.consumed)
            keep = 1'b0;
        else if (w.skip && (item.in_byte[7:6] == 2'b10))
            keep = 1'b0;
        else
            w.skip = 1'b0;

        if (item.end_of_string)
        begin
            if (keep)
                w = process_byte(w, item.in_byte, 8'h00);
            w = close_token(w);
            w = emit(w, KIND_TOTAL, 8'(w.total));
            w.len    = '0;
            w.total  = '0;
            w.letter = 1'b0;
            w.digit  = 1'b0;
            w.odd    = 1'b1;
            w.skip   = 1'b0;
            pending_byte_next  = 8'h00;
            pending_valid_next = 1'b0;
        end
        else if (keep)
        begin
            pending_byte_next  = item.in_byte;
            pending_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_byte_reg  <= 8'h00;
            pending_valid_reg <= 1'b0;
            skip_reg          <= 1'b0;
            len_reg           <= '0;
            total_reg         <= '0;
            letter_reg        <= 1'b0;
            digit_reg         <= 1'b0;
            odd_reg           <= 1'b1;
        end
        else if (accept)
        begin
            pending_byte_reg  <= pending_byte_next;
            pending_valid_reg <= pending_valid_next;
            skip_reg          <= w.skip;
            len_reg           <= w.len;
            total_reg         <= w.total;
            letter_reg        <= w.letter;
            digit_reg         <= w.digit;
            odd_reg           <= w.odd;
        end
    end

    assign n_minus_one     = w.n - RES_CNT_W'(1);
    assign bundle_push     = accept && (w.n != '0);
    assign bundle.res      = w.res;
    assign bundle.last_idx = n_minus_one[RES_IDX_W-1:0];

endmodule

// ===== design/utf8tok_queue.sv =====
// Short queue of result bundles between the front and back ends.
// Depends on utf8tok_pkg.
module utf8tok_queue
    import utf8tok_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  bundle_t wr_data,
    output logic    full,
    input  logic    rd_en,
    output bundle_t rd_data,
    output logic    empty
);

    bundle_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_wr, do_rd;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_reg + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
        end
    end

endmodule

// ===== design/utf8tok_back.sv =====
// Back end: unrolls each bundle into single results, marks the last of a run
// and holds them in the output queue. Depends on utf8tok_pkg.
module utf8tok_back
    import utf8tok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  bundle_t   q_head,
    output logic      q_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    out_item_t              out_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [OUT_PTR_W:0]     count_reg;
    logic [RES_IDX_W-1:0]   idx_reg;
    logic                   move, head_last, pop_ok;
    result_t                cur;

    assign cur       = q_head.res[idx_reg];
    assign head_last = (idx_reg == q_head.last_idx);
    assign move      = !q_empty && (count_reg != (OUT_PTR_W+1)'(OUT_DEPTH));
    assign q_pop     = move && head_last;
    assign empty     = (count_reg == '0);
    assign pop_ok    = pop && !empty;
    assign result    = out_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (move)
            out_mem[wr_ptr_reg] <= '{kind: cur.kind, value: cur.value, last_in_run: head_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            if (move)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
                // advance within the bundle, restart at the next one
                idx_reg    <= head_last ? '0 : idx_reg + RES_IDX_W'(1);
            end
            if (pop_ok)
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            count_reg <= count_reg + (OUT_PTR_W+1)'(move) - (OUT_PTR_W+1)'(pop_ok);
        end
    end

endmodule

// ===== design/utf8tok_checker.sv =====
// Port checker for the tokeniser top level, attached by bind.
// Depends on utf8tok_pkg and utf8_folding_word_tokenizer_core.
module utf8tok_checker
    import utf8tok_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input in_item_t  item,
    input logic      empty,
    input logic      pop,
    input out_item_t result
);

    a_item_known: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> !$isunknown(item))
        else $error("unknown item on transfer");

    // Hold the waiting result until it is transferred
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before transfer");

    a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_TOTAL)) |-> result.last_in_run)
        else $error("token total not last of its run");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_END)) |-> (result.value == 8'h00))
        else $error("end of token carries a value");

    a_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_TOTAL)) |-> (result.value <= 8'(TOKEN_LIMIT)))
        else $error("token total above limit");

endmodule

bind utf8_folding_word_tokenizer_core utf8tok_checker u_checker (.*);
